### src/vsm_pkg.sv
// Package for the vector softmax block: widths, state encoding and exponent tables.
// Used by vector_softmax, vsm_exp and vsm_div; depends on nothing.
package vsm_pkg;

	localparam int MaxLen = 64;
	localparam int AddrW = $clog2(MaxLen);
	localparam int CntW = $clog2(MaxLen + 1);
	localparam int ElemW = 17;
	localparam int SumW = 23;
	localparam int ProbW = 17;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_EXP_RD,
		ST_EXP_CALC,
		ST_EXP_WR,
		ST_DIV_RD,
		ST_DIV_LOAD,
		ST_DIV_RUN,
		ST_DIV_OUT
	} vsm_state_t;

	// Control handed from the sequencer to the divider.
	typedef struct packed {
		logic start;
		logic [ElemW-1:0] numer;
	} vsm_div_req_t;

	// 2^(-i/16) in Q1.16.
	function automatic logic [16:0] pow2_16th(input logic [3:0] i);
		logic [16:0] v;
		case (i)
			4'd0: v = 17'd65536;
			4'd1: v = 17'd62757;
			4'd2: v = 17'd60097;
			4'd3: v = 17'd57549;
			4'd4: v = 17'd55109;
			4'd5: v = 17'd52773;
			4'd6: v = 17'd50535;
			4'd7: v = 17'd48393;
			4'd8: v = 17'd46341;
			4'd9: v = 17'd44376;
			4'd10: v = 17'd42495;
			4'd11: v = 17'd40693;
			4'd12: v = 17'd38968;
			4'd13: v = 17'd37316;
			4'd14: v = 17'd35734;
			default: v = 17'd34219;
		endcase
		return v;
	endfunction

	// 2^(-j/256) in Q1.16.
	function automatic logic [16:0] pow2_256th(input logic [3:0] j);
		logic [16:0] v;
		case (j)
			4'd0: v = 17'd65536;
			4'd1: v = 17'd65359;
			4'd2: v = 17'd65182;
			4'd3: v = 17'd65006;
			4'd4: v = 17'd64830;
			4'd5: v = 17'd64655;
			4'd6: v = 17'd64480;
			4'd7: v = 17'd64306;
			4'd8: v = 17'd64132;
			4'd9: v = 17'd63958;
			4'd10: v = 17'd63785;
			4'd11: v = 17'd63613;
			4'd12: v = 17'd63441;
			4'd13: v = 17'd63269;
			4'd14: v = 17'd63098;
			default: v = 17'd62928;
		endcase
		return v;
	endfunction

endpackage

### src/vector_softmax.sv
// Vector softmax top level. Elements are loaded one per accepted request; after the final element,
// an exponent pass runs per element (RAM read, exp stage one, exp stage two with write back), then
// a divide pass runs per element (RAM read, operand load, 34 divider steps, done, result) on the
// bit-serial divider. The block handles one vector at a time; busy is high from the final element
// until the cycle of the last result. The receiver cannot stall. Reset is asynchronous, active low;
// the RAM is not cleared.
module vector_softmax
	import vsm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [15:0]       logit,
	input  logic              last_in,
	output logic              strobe,
	output logic [ProbW-1:0]  probability,
	output logic [SumW-1:0]   exp_sum,
	output logic              last_out
);

	vsm_state_t state_q, state_d;
	logic [CntW-1:0]  count_q;
	logic [AddrW-1:0] idx_q;
	logic signed [15:0] max_q;
	logic [SumW-1:0]  sum_q;
	logic             accept;
	logic             ram_we;
	logic [AddrW-1:0] ram_waddr, ram_raddr;
	logic [ElemW-1:0] ram_wdata, ram_rdata;
	logic [15:0]      diff;
	logic [16:0]      e_val;
	logic             idx_last;
	logic             div_done;
	logic [ProbW-1:0] quot;
	vsm_div_req_t     div_req;

	assign accept = start && !busy;
	assign idx_last = (CntW'(idx_q) + 1'b1) == count_q;

	vsm_ram #(.Width(ElemW), .Depth(MaxLen)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Difference from the maximum, wrapped to 16 bits.
	assign diff = 16'(max_q - $signed(ram_rdata[15:0]));

	vsm_exp u_exp (
		.clk(clk),
		.d  (diff),
		.e  (e_val)
	);

	// The divider takes its operand once the RAM read issued in DIV_RD has returned.
	assign div_req.start = (state_q == ST_DIV_LOAD);
	assign div_req.numer = ram_rdata;

	vsm_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.sum   (sum_q),
		.done  (div_done),
		.quot  (quot)
	);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (accept && last_in) begin
					state_d = ST_EXP_RD;
				end
			end
			ST_EXP_RD: state_d = ST_EXP_CALC;
			ST_EXP_CALC: state_d = ST_EXP_WR;
			ST_EXP_WR: state_d = idx_last ? ST_DIV_RD : ST_EXP_RD;
			ST_DIV_RD: state_d = ST_DIV_LOAD;
			ST_DIV_LOAD: state_d = ST_DIV_RUN;
			ST_DIV_RUN: state_d = div_done ? ST_DIV_OUT : ST_DIV_RUN;
			ST_DIV_OUT: state_d = idx_last ? ST_LOAD : ST_DIV_RD;
			default: state_d = ST_LOAD;
		endcase
	end

	// Output and memory-control logic.
	always_comb begin
		busy = (state_q != ST_LOAD);
		ram_we = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = e_val;
		ram_raddr = idx_q;
		case (state_q)
			ST_LOAD: begin
				ram_we = accept && (count_q < CntW'(MaxLen));
				ram_waddr = count_q[AddrW-1:0];
				ram_wdata = {1'b0, logit};
			end
			ST_EXP_WR: ram_we = 1'b1;
			default: ;
		endcase
	end

	// Sequencer registers. The exp unit reads RAM data in EXP_CALC and yields e in EXP_WR.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			idx_q <= '0;
			max_q <= 16'sh8000;
			sum_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_LOAD: begin
					idx_q <= '0;
					if (accept && count_q < CntW'(MaxLen)) begin
						count_q <= count_q + 1'b1;
						if ($signed(logit) > max_q) begin
							max_q <= logit;
						end
					end
				end
				ST_EXP_WR: begin
					sum_q <= sum_q + SumW'(e_val);
					idx_q <= idx_last ? '0 : idx_q + 1'b1;
				end
				ST_DIV_OUT: begin
					if (idx_last) begin
						idx_q <= '0;
						count_q <= '0;
						max_q <= 16'sh8000;
						sum_q <= '0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Result registers: one strobe per stored element.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
			last_out <= 1'b0;
		end else begin
			strobe <= (state_q == ST_DIV_OUT);
			last_out <= (state_q == ST_DIV_OUT) && idx_last;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV_OUT) begin
			probability <= quot;
			exp_sum <= sum_q;
		end
	end

`ifndef SYNTHESIS
	a_last_has_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last_out |-> strobe) else $error("last_out without strobe");
	a_busy_no_load_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXP_WR) |-> ram_we && !accept) else $error("write-back slip");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(MaxLen)) else $error("count overflow");
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		last_out |-> !busy) else $error("busy after final result");
`endif

endmodule

### src/vsm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package dependencies.
module vsm_ram #(
	parameter int Width = 17,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/vsm_exp.sv
// Two-stage exp(-d/256) unit: log2 scaling, then table product and shift.
// Depends on vsm_pkg.
module vsm_exp
	import vsm_pkg::*;
(
	input  logic        clk,
	input  logic [15:0] d,
	output logic [16:0] e
);

	logic [33:0] t;
	logic [17:0] u_s1;
	logic [33:0] prod;
	logic [16:0] m;
	logic [17:0] m2;
	logic [9:0]  k;

	// Stage one: scale by log2(e) and round to Q.8.
	assign t = 34'(d) * 34'd94548;
	always_ff @(posedge clk) begin
		u_s1 <= 18'((t + 34'd32768) >> 16);
	end

	// Stage two: table product, then shift right by the integer part with rounding.
	assign k = u_s1[17:8];
	assign prod = 34'(pow2_16th(u_s1[7:4])) * 34'(pow2_256th(u_s1[3:0]));
	assign m = 17'((prod + 34'd32768) >> 16);
	assign m2 = {m, 1'b0} >> k;
	always_comb begin
		if (k >= 10'd18) begin
			e = '0;
		end else begin
			e = 17'((19'(m2) + 19'd1) >> 1);
		end
	end

endmodule

### src/vsm_div.sv
// Restoring radix-2 divider for round(numer * 65536 / sum).
// Depends on vsm_pkg.
module vsm_div
	import vsm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  vsm_div_req_t       req,
	input  logic [SumW-1:0]    sum,
	output logic               done,
	output logic [ProbW-1:0]   quot
);

	localparam int DividW = ElemW + 16 + 1;
	localparam int StepW = $clog2(DividW + 1);

	logic [DividW-1:0] divid_q;
	logic [SumW:0]     rem_q;
	logic [StepW-1:0]  step_q;
	logic              busy_q;
	logic [SumW+1:0]   shifted;

	// Partial remainder shifted left with the next dividend bit.
	assign shifted = {rem_q, divid_q[DividW-1]};

	// One quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= StepW'(DividW);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == StepW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	// Datapath: numerator * 2^16 + sum/2, then shift-subtract.
	always_ff @(posedge clk) begin
		if (req.start) begin
			divid_q <= DividW'({req.numer, 16'd0}) + DividW'(sum >> 1);
			rem_q <= '0;
		end else if (busy_q) begin
			if (shifted >= (SumW+2)'(sum)) begin
				rem_q <= (SumW+1)'(shifted - (SumW+2)'(sum));
				divid_q <= {divid_q[DividW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[SumW:0];
				divid_q <= {divid_q[DividW-2:0], 1'b0};
			end
		end
	end

	assign quot = divid_q[ProbW-1:0];

`ifndef SYNTHESIS
	a_done_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("divider done held");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy_q) else $error("divider done while busy");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && (sum != '0) |-> (rem_q < (SumW+1)'(sum))) else $error("remainder overflow");
`endif

endmodule

### verif/tb_vector_softmax.sv
// Self-checking testbench for vector_softmax: drives logit vectors as requests and checks each
// probability, exponential sum and last flag against a built-in fixed-point softmax predictor.
// Depends on vsm_pkg and vector_softmax in src.
`timescale 1ns / 1ps

module tb_vector_softmax;
	import vsm_pkg::*;

	localparam int WatchdogLimit = 40000;
	localparam int DrainCycles = 200;

	typedef struct {
		logic [ProbW-1:0] probability;
		logic [SumW-1:0] exp_sum;
		logic last_out;
	} softmax_result_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [15:0] logit;
	logic last_in;
	logic strobe;
	logic [ProbW-1:0] probability;
	logic [SumW-1:0] exp_sum;
	logic last_out;

	// Predictor state: stored logits of the open vector and their running maximum.
	logic signed [15:0] pending_logits[$];
	logic signed [15:0] vector_max;
	softmax_result_t expected_probs[$];

	int sender_idle_pct;
	int failures;
	int requests_sent;
	int results_seen;
	int vectors_sent;
	int idle_cycles;
	bit timed_out;

	vector_softmax u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.logit(logit),
		.last_in(last_in),
		.strobe(strobe),
		.probability(probability),
		.exp_sum(exp_sum),
		.last_out(last_out)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Table lookups written out as arrays, independent of the package functions.
	localparam int unsigned Sixteenths[16] = '{65536, 62757, 60097, 57549, 55109, 52773,
		50535, 48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219};
	localparam int unsigned TwoFiftySixths[16] = '{65536, 65359, 65182, 65006, 64830, 64655,
		64480, 64306, 64132, 63958, 63785, 63613, 63441, 63269, 63098, 62928};

	// exp(-d/256) in Q1.16 by table lookup and shifts.
	function automatic logic [16:0] exp_of_distance(input logic [15:0] d);
		logic [63:0] scaled;
		logic [63:0] log2_q8;
		logic [63:0] shift;
		logic [63:0] mant;
		scaled = 64'(d) * 64'd94548;
		log2_q8 = (scaled + 64'd32768) >> 16;
		shift = log2_q8 >> 8;
		mant = (64'(Sixteenths[log2_q8[7:4]]) * 64'(TwoFiftySixths[log2_q8[3:0]])
			+ 64'd32768) >> 16;
		if (shift >= 18)
			return '0;
		return 17'((((mant << 1) >> shift) + 64'd1) >> 1);
	endfunction

	// Add one logit to the open vector; on the final one, queue the expected probabilities.
	task automatic predict_softmax(input logic [15:0] x, input logic fin);
		logic [16:0] exps[$];
		logic [22:0] total;
		logic [63:0] p;
		softmax_result_t r;
		if (pending_logits.size() < MaxLen) begin
			pending_logits = {pending_logits, x};
			if ($signed(x) > vector_max)
				vector_max = x;
		end
		if (!fin)
			return;
		total = '0;
		foreach (pending_logits[n]) begin
			exps = {exps, exp_of_distance(16'(vector_max - pending_logits[n]))};
			total = total + 23'(exps[n]);
		end
		foreach (exps[n]) begin
			p = (total != 0) ? (64'(exps[n]) * 64'd65536 + 64'(total >> 1)) / 64'(total) : 0;
			r = '{17'(p), total, n == exps.size() - 1};
			expected_probs = {expected_probs, r};
		end
		pending_logits.delete();
		vector_max = -16'sd32768;
		vectors_sent++;
	endtask

	// Send one request, idling beforehand at the current sender rate.
	task automatic send_logit(input logic [15:0] x, input logic fin);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			logit <= 16'($urandom);
			last_in <= 1'($urandom);
			@(negedge clk);
		end
		start <= 1'b1;
		logit <= x;
		last_in <= fin;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_softmax(x, fin);
		requests_sent++;
		@(negedge clk);
	endtask

	// Results are checked in order as they appear.
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			results_seen++;
			if (expected_probs.size() == 0) begin
				$error("Unexpected result: probability %0d", probability);
				failures++;
			end else begin
				softmax_result_t exp_r;
				exp_r = expected_probs.pop_front();
				if (probability !== exp_r.probability) begin
					$error("probability: expected %0d, got %0d", exp_r.probability, probability);
					failures++;
				end
				if (exp_sum !== exp_r.exp_sum) begin
					$error("exp_sum: expected %0d, got %0d", exp_r.exp_sum, exp_sum);
					failures++;
				end
				if (last_out !== exp_r.last_out) begin
					$error("last_out: expected %0d, got %0d", exp_r.last_out, last_out);
					failures++;
				end
			end
		end
	end

	// Watchdog: counts cycles in which no request is accepted and no result appears.
	always @(posedge clk) begin
		if ((start && !busy) || strobe)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			timed_out = 1'b1;
			$display("Stalled after %0d requests and %0d results.", requests_sent, results_seen);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Send a vector of the given length with random logits spread within the given span.
	task automatic send_random_vector(input int len, input int span);
		logic signed [15:0] base;
		base = 16'($urandom);
		for (int n = 0; n < len; n++)
			send_logit(16'(base + $signed($urandom_range(2 * span) - span)), n == len - 1);
	endtask

	// Directed vectors: field extremes, single element, equal values.
	task automatic test_directed();
		send_logit(16'h0100, 1'b1);
		send_logit(16'h8000, 1'b0);
		send_logit(16'h7FFF, 1'b1);
		send_logit(16'h0000, 1'b0);
		send_logit(16'h0000, 1'b0);
		send_logit(16'h0000, 1'b1);
		send_logit(16'hFFFF, 1'b0);
		send_logit(16'h8000, 1'b0);
		send_logit(16'h8001, 1'b1);
		send_logit(16'h0200, 1'b0);
		send_logit(16'h0000, 1'b0);
		send_logit(16'h0C00, 1'b0);
		send_logit(16'h0B80, 1'b1);
		send_logit(16'h5555, 1'b0);
		send_logit(16'hAAAA, 1'b1);
	endtask

	// Full vector plus extra elements that must be dropped.
	task automatic test_overflow();
		for (int n = 0; n < MaxLen + 3; n++)
			send_logit(16'(n == MaxLen + 1 ? 16'h7FFF : $urandom_range(2047)), n == MaxLen + 2);
	endtask

	// Random vectors, mostly short, some long, spans from narrow to full range.
	task automatic test_random(input int budget);
		int len;
		int span;
		while (budget > 0) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(MaxLen, 20) : $urandom_range(8, 1);
			span = ($urandom_range(3) == 0) ? 32767 : $urandom_range(3000, 0);
			send_random_vector(len, span);
			budget -= len;
		end
	endtask

	initial begin
		failures = 0;
		requests_sent = 0;
		results_seen = 0;
		vectors_sent = 0;
		idle_cycles = 0;
		timed_out = 1'b0;
		vector_max = -16'sd32768;
		start = 1'b0;
		logit = '0;
		last_in = 1'b0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		sender_idle_pct = 25;
		test_directed();
		test_overflow();
		test_random(50);
		sender_idle_pct = 74;
		test_random(50);
		sender_idle_pct = 0;
		test_random(50);
		start <= 1'b0;

		while (expected_probs.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("Covered %0d requests in %0d vectors, %0d results checked.",
			requests_sent, vectors_sent, results_seen);
		if (failures == 0 && !timed_out)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
